@@ rtl/core/bbfa_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bbfa_pkg: shared codes for the block bitmap file allocator
// Request action codes and result status codes.
// ----------------------------------------------------------------------------
package bbfa_pkg;

	// request action
	typedef enum logic [1:0] {
		ACT_CREATE = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_READ   = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	// result status
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_INVALID   = 3'd1,
		ST_TOO_LARGE = 3'd2,
		ST_NO_SPACE  = 3'd3,
		ST_NOT_FOUND = 3'd4
	} status_t;

endpackage
`default_nettype wire

@@ rtl/core/block_bitmap_file_allocator_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// block_bitmap_file_allocator_unit: first-fit block allocator for numbered files
// A request word (action, file_id, size_bytes) is taken when start is high and
// busy is low. One result word comes back per request, flagged by a one-cycle
// done strobe; the receiver cannot stall it and must take it in that cycle.
// The block owner table is a single-port-write, registered-read memory of
// TOTAL_BLOCKS entries. Create, delete and read walk it one entry per cycle.
// Rejected and trivial requests, and a create of a new file with no space,
// make no pass; read, delete, a create of a new file and a replace that runs
// out of space make one pass; a create replacing an existing file makes two.
// The final cycle turns the used count into the percent by a constant multiply.
// At most one request is in flight; busy drops in the cycle done pulses, so the
// next request can be taken at the edge that takes the result.
// After reset the block runs a clearing pass over the owner table with busy
// held high; no request is taken meanwhile.
// ----------------------------------------------------------------------------
module block_bitmap_file_allocator_unit
	import bbfa_pkg::*;
#(
	parameter int TOTAL_BLOCKS = 512,
	parameter int BLOCK_BYTES  = 4096,
	parameter int MAX_FILES    = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  action,
	input  wire logic [5:0]  file_id,
	input  wire logic [21:0] size_bytes,
	output logic             done,
	output logic [2:0]       status,
	output logic [9:0]       file_blocks,
	output logic [21:0]      file_size,
	output logic [9:0]       used_blocks,
	output logic [6:0]       usage_percent
);

	localparam int AW  = $clog2(TOTAL_BLOCKS);
	localparam int UW  = $clog2(TOTAL_BLOCKS + 1);
	localparam int CW  = $clog2(MAX_FILES + 1);
	localparam int FW  = (MAX_FILES > 2) ? $clog2(MAX_FILES) : 1;
	localparam int CAP = TOTAL_BLOCKS * BLOCK_BYTES;
	localparam int BW  = $clog2(CAP + BLOCK_BYTES + 1);
	localparam logic [AW-1:0] LAST = AW'(TOTAL_BLOCKS - 1);
	// reciprocal of TOTAL_BLOCKS scaled by 100, exact for used <= TOTAL_BLOCKS
	localparam int     PCT_SH = 2 * UW;
	localparam longint PCT_K  = ((longint'(100) << PCT_SH) + longint'(TOTAL_BLOCKS)
		- longint'(1)) / longint'(TOTAL_BLOCKS);
	localparam int     KW     = $clog2(PCT_K + 1);
	localparam int     PW     = UW + KW;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_REL,
		S_SPACE,
		S_CLAIM,
		S_COUNT,
		S_REPORT
	} state_t;

	state_t            state_q;
	action_t           act_q;
	logic [5:0]        id_q;
	logic [21:0]       size_q;

	// scan engine
	logic [AW-1:0]     scan_addr_q;
	logic              scan_active_q;
	logic              vld_s1;
	logic [AW-1:0]     addr_s1;
	logic [CW-1:0]     owner_s1;

	// allocator state
	logic [UW-1:0]        used_q;
	logic [MAX_FILES-1:0] present_q;
	logic [UW-1:0]        got_q;
	logic [BW-1:0]        bytes_q;
	logic [21:0]          size_rd_q;

	// result registers
	status_t           status_q;
	logic [9:0]        fblk_q;
	logic [21:0]       fsize_q;
	logic [9:0]        used_out_q;
	logic [6:0]        usage_q;
	logic              done_q;

	// memories
	logic [CW-1:0]     owner_mem [TOTAL_BLOCKS];
	logic [21:0]       size_mem [MAX_FILES];

	logic              owner_wr_en;
	logic [AW-1:0]     owner_wr_addr;
	logic [CW-1:0]     owner_wr_data;

	logic [FW-1:0]     idx;
	logic [CW-1:0]     code;
	logic              id_ok;
	logic              scan_last;
	logic              need_more;
	logic              hit;
	logic [UW-1:0]     got_nxt;
	logic [UW-1:0]     free_blocks;
	logic              no_space;
	logic [PW-1:0]     pct_prod;
	logic [6:0]        pct_nxt;
	logic              size_we;

	// request decode
	assign idx       = FW'(id_q);
	assign code      = CW'(id_q) + CW'(1);
	assign id_ok     = 32'(id_q) < 32'(MAX_FILES);
	assign scan_last = vld_s1 && (addr_s1 == LAST);
	assign need_more = 32'(bytes_q) < 32'(size_q);

	// blocks that count toward the file in this pass
	always_comb begin
		hit = 1'b0;
		case (state_q)
			S_CLAIM: hit = vld_s1 && (owner_s1 == '0) && need_more;
			S_COUNT: hit = vld_s1 && (owner_s1 == code);
			default: hit = 1'b0;
		endcase
	end
	assign got_nxt = got_q + UW'(hit);

	// space check: free blocks times block size against requested bytes
	assign free_blocks = UW'(TOTAL_BLOCKS) - used_q;
	assign no_space    = (32'(free_blocks) * 32'(BLOCK_BYTES)) < 32'(size_q);

	// used * 100 / TOTAL_BLOCKS, floored, by reciprocal multiply
	assign pct_prod = PW'(used_q) * PW'(PCT_K);
	assign pct_nxt  = pct_prod[PCT_SH +: 7];

	// owner table write port
	always_comb begin
		owner_wr_en   = 1'b0;
		owner_wr_addr = addr_s1;
		owner_wr_data = '0;
		case (state_q)
			S_CLEAR: begin
				owner_wr_en   = 1'b1;
				owner_wr_addr = scan_addr_q;
			end
			S_REL: begin
				owner_wr_en = vld_s1 && (owner_s1 == code);
			end
			S_CLAIM: begin
				owner_wr_en   = hit;
				owner_wr_data = code;
			end
			default: owner_wr_en = 1'b0;
		endcase
	end

	// owner table: write at the data stage, read ahead by one entry
	always_ff @(posedge clk) begin
		if (owner_wr_en) begin
			owner_mem[owner_wr_addr] <= owner_wr_data;
		end
		if (scan_active_q) begin
			owner_s1 <= owner_mem[scan_addr_q];
		end
		addr_s1 <= scan_addr_q;
	end

	// stored size table
	assign size_we = (state_q == S_CLAIM) && scan_last;
	always_ff @(posedge clk) begin
		if (size_we) begin
			size_mem[idx] <= size_q;
		end
		if (state_q == S_CHECK) begin
			size_rd_q <= size_mem[idx];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			act_q         <= ACT_CREATE;
			id_q          <= '0;
			size_q        <= '0;
			scan_addr_q   <= '0;
			scan_active_q <= 1'b0;
			vld_s1        <= 1'b0;
			used_q        <= '0;
			present_q     <= '0;
			got_q         <= '0;
			bytes_q       <= '0;
			status_q      <= ST_OK;
			fblk_q        <= '0;
			fsize_q       <= '0;
			used_out_q    <= '0;
			usage_q       <= '0;
			done_q        <= 1'b0;
		end else begin
			done_q <= (state_q == S_REPORT);
			vld_s1 <= scan_active_q;

			// address walk for the running pass
			if (scan_active_q) begin
				if (scan_addr_q == LAST) begin
					scan_active_q <= 1'b0;
				end else begin
					scan_addr_q <= scan_addr_q + AW'(1);
				end
			end

			case (state_q)
				S_CLEAR: begin
					if (scan_addr_q == LAST) begin
						scan_addr_q <= '0;
						state_q     <= S_IDLE;
					end else begin
						scan_addr_q <= scan_addr_q + AW'(1);
					end
				end

				S_IDLE: begin
					if (start) begin
						act_q   <= action_t'(action);
						id_q    <= file_id;
						size_q  <= size_bytes;
						state_q <= S_CHECK;
					end
				end

				S_CHECK: begin
					fblk_q  <= '0;
					fsize_q <= '0;
					got_q   <= '0;
					case (act_q)
						ACT_CREATE: begin
							if (size_q == '0) begin
								status_q <= ST_INVALID;
								state_q  <= S_REPORT;
							end else if (32'(size_q) > 32'(CAP)) begin
								status_q <= ST_TOO_LARGE;
								state_q  <= S_REPORT;
							end else if (!id_ok) begin
								status_q <= ST_NOT_FOUND;
								state_q  <= S_REPORT;
							end else if (present_q[idx]) begin
								status_q      <= ST_OK;
								scan_addr_q   <= '0;
								scan_active_q <= 1'b1;
								state_q       <= S_REL;
							end else begin
								status_q <= ST_OK;
								state_q  <= S_SPACE;
							end
						end
						ACT_DELETE: begin
							if (!id_ok || !present_q[idx]) begin
								status_q <= ST_NOT_FOUND;
								state_q  <= S_REPORT;
							end else begin
								status_q      <= ST_OK;
								scan_addr_q   <= '0;
								scan_active_q <= 1'b1;
								state_q       <= S_REL;
							end
						end
						ACT_READ: begin
							if (!id_ok || !present_q[idx]) begin
								status_q <= ST_NOT_FOUND;
								state_q  <= S_REPORT;
							end else begin
								status_q      <= ST_OK;
								scan_addr_q   <= '0;
								scan_active_q <= 1'b1;
								state_q       <= S_COUNT;
							end
						end
						ACT_NONE: begin
							status_q <= ST_OK;
							state_q  <= S_REPORT;
						end
						default: begin
							status_q <= ST_OK;
							state_q  <= S_REPORT;
						end
					endcase
				end

				// free every block of the file
				S_REL: begin
					if (owner_wr_en) begin
						used_q <= used_q - UW'(1);
					end
					if (scan_last) begin
						present_q[idx] <= 1'b0;
						state_q <= (act_q == ACT_CREATE) ? S_SPACE : S_REPORT;
					end
				end

				S_SPACE: begin
					if (no_space) begin
						status_q <= ST_NO_SPACE;
						state_q  <= S_REPORT;
					end else begin
						got_q         <= '0;
						bytes_q       <= '0;
						scan_addr_q   <= '0;
						scan_active_q <= 1'b1;
						state_q       <= S_CLAIM;
					end
				end

				// claim the lowest free blocks until the size is covered
				S_CLAIM: begin
					got_q <= got_nxt;
					if (hit) begin
						used_q  <= used_q + UW'(1);
						bytes_q <= bytes_q + BW'(BLOCK_BYTES);
					end
					if (scan_last) begin
						present_q[idx] <= 1'b1;
						fblk_q  <= 10'(got_nxt);
						fsize_q <= size_q;
						state_q <= S_REPORT;
					end
				end

				// count blocks owned by the file
				S_COUNT: begin
					got_q <= got_nxt;
					if (scan_last) begin
						fblk_q  <= 10'(got_nxt);
						fsize_q <= size_rd_q;
						state_q <= S_REPORT;
					end
				end

				// usage figures and result strobe
				S_REPORT: begin
					usage_q    <= pct_nxt;
					used_out_q <= 10'(used_q);
					state_q    <= S_IDLE;
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ports
	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign status        = status_q;
	assign file_blocks   = fblk_q;
	assign file_size     = fsize_q;
	assign used_blocks   = used_out_q;
	assign usage_percent = usage_q;

	// checks
	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a request in flight");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= UW'(TOTAL_BLOCKS))
		else $error("used block count above disk size");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(owner_wr_en && scan_active_q) |-> (owner_wr_addr != scan_addr_q))
		else $error("owner table read and write hit the same entry");

	a_pct_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (usage_percent <= 7'd100))
		else $error("usage percent above 100");

endmodule
`default_nettype wire

@@ tb/bbfa_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bbfa_checker: result checker for the block bitmap file allocator
// Mirrors the block owner table from each accepted request word and compares
// every result word, field by field and in order, with its prediction.
// ----------------------------------------------------------------------------
module bbfa_checker
	import bbfa_pkg::*;
#(
	parameter int TOTAL_BLOCKS = 512,
	parameter int BLOCK_BYTES  = 4096,
	parameter int MAX_FILES    = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic [1:0]  action,
	input  wire logic [5:0]  file_id,
	input  wire logic [21:0] size_bytes,
	input  wire logic        done,
	input  wire logic [2:0]  status,
	input  wire logic [9:0]  file_blocks,
	input  wire logic [21:0] file_size,
	input  wire logic [9:0]  used_blocks,
	input  wire logic [6:0]  usage_percent,
	output int               mismatches,
	output int               awaiting,
	output int               checked,
	output int               refusals,
	output int               peak_used
);

	typedef struct {
		status_t     status;
		logic [9:0]  file_blocks;
		logic [21:0] file_size;
		logic [9:0]  used_blocks;
		logic [6:0]  usage_percent;
	} reply_t;

	localparam longint CAPACITY = longint'(TOTAL_BLOCKS) * longint'(BLOCK_BYTES);

	// mirrored disk state: owner code per block is 0 for free, else file id + 1
	logic [6:0]  owner_of [TOTAL_BLOCKS];
	bit          file_exists [MAX_FILES];
	logic [21:0] size_of [MAX_FILES];
	int          blocks_in_use;

	// result words still owed by the block, oldest first
	reply_t predicted_replies [$];

	task automatic note_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [31:0] seen,
			input logic [31:0] wanted);
		if (seen !== wanted)
			note_mismatch($sformatf("%s got %0d expected %0d", name, seen, wanted));
	endtask

	// free every block of one file and drop the file
	task automatic release_blocks(input logic [5:0] id);
		logic [6:0] code;
		code = {1'b0, id} + 7'd1;
		for (int i = 0; i < TOTAL_BLOCKS; i++) begin
			if (owner_of[i] == code) begin
				owner_of[i] = '0;
				blocks_in_use--;
			end
		end
		file_exists[id] = 1'b0;
	endtask

	// apply one request word to the mirror and work out its result word
	task automatic predict_reply(input action_t act, input logic [5:0] id,
			input logic [21:0] sz, output reply_t r);
		int         need;
		int         got;
		logic [6:0] code;
		bit         id_ok;
		code = {1'b0, id} + 7'd1;
		id_ok = int'(id) < MAX_FILES;
		got = 0;
		r.status = ST_OK;
		r.file_blocks = '0;
		r.file_size = '0;
		case (act)
			ACT_CREATE: begin
				if (sz == '0) begin
					r.status = ST_INVALID;
				end else if (longint'(sz) > CAPACITY) begin
					r.status = ST_TOO_LARGE;
				end else if (!id_ok) begin
					r.status = ST_NOT_FOUND;
				end else begin
					need = (int'(sz) + BLOCK_BYTES - 1) / BLOCK_BYTES;
					// a replaced file is gone even if the new claim fails
					if (file_exists[id])
						release_blocks(id);
					if (TOTAL_BLOCKS - blocks_in_use < need) begin
						r.status = ST_NO_SPACE;
					end else begin
						// first fit, lowest free blocks, holes allowed
						for (int i = 0; i < TOTAL_BLOCKS && got < need; i++) begin
							if (owner_of[i] == '0) begin
								owner_of[i] = code;
								got++;
							end
						end
						blocks_in_use += got;
						file_exists[id] = 1'b1;
						size_of[id] = sz;
						r.file_blocks = 10'(got);
						r.file_size = sz;
					end
				end
			end
			ACT_DELETE: begin
				if (!id_ok || !file_exists[id])
					r.status = ST_NOT_FOUND;
				else
					release_blocks(id);
			end
			ACT_READ: begin
				if (!id_ok || !file_exists[id]) begin
					r.status = ST_NOT_FOUND;
				end else begin
					for (int i = 0; i < TOTAL_BLOCKS; i++)
						if (owner_of[i] == code)
							got++;
					r.file_blocks = 10'(got);
					r.file_size = size_of[id];
				end
			end
			default: begin
			end
		endcase
		r.used_blocks = 10'(blocks_in_use);
		r.usage_percent = 7'(blocks_in_use * 100 / TOTAL_BLOCKS);
	endtask

	// watch both channels; the result word is handled before a new request
	always @(posedge clk or negedge arst_n) begin : watch
		reply_t want;
		reply_t fresh;
		if (!arst_n) begin
			for (int i = 0; i < TOTAL_BLOCKS; i++)
				owner_of[i] = '0;
			for (int f = 0; f < MAX_FILES; f++) begin
				file_exists[f] = 1'b0;
				size_of[f] = '0;
			end
			blocks_in_use = 0;
			predicted_replies.delete();
			mismatches = 0;
			checked = 0;
			refusals = 0;
			peak_used = 0;
			awaiting <= 0;
		end else begin
			// result word
			if (done) begin
				if (predicted_replies.size() == 0) begin
					note_mismatch("result word with no request outstanding");
				end else begin
					want = predicted_replies.pop_front();
					check_field("status", 32'(status), 32'(want.status));
					check_field("file_blocks", 32'(file_blocks), 32'(want.file_blocks));
					check_field("file_size", 32'(file_size), 32'(want.file_size));
					check_field("used_blocks", 32'(used_blocks), 32'(want.used_blocks));
					check_field("usage_percent", 32'(usage_percent),
						32'(want.usage_percent));
					checked++;
				end
			end
			// request word
			if (start && !busy) begin
				predict_reply(action_t'(action), file_id, size_bytes, fresh);
				predicted_replies = {predicted_replies, fresh};
				if (fresh.status == ST_NO_SPACE)
					refusals++;
				if (blocks_in_use > peak_used)
					peak_used = blocks_in_use;
			end
			awaiting <= predicted_replies.size();
		end
	end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for the block bitmap file allocator
// Drives directed and random create, delete, read and no-op request words with
// random sender gaps; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb;
	import bbfa_pkg::*;

	localparam int TOTAL_BLOCKS = 512;
	localparam int BLOCK_BYTES  = 4096;
	localparam int MAX_FILES    = 64;
	localparam int CAPACITY     = TOTAL_BLOCKS * BLOCK_BYTES;
	localparam int RANDOM_WORDS = 1000;
	localparam int QUIET_TAIL   = 150;
	localparam int STALL_LIMIT  = 8000;
	localparam int DRAIN_CYCLES = 2 * TOTAL_BLOCKS + 50;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  action = ACT_CREATE;
	logic [5:0]  file_id = '0;
	logic [21:0] size_bytes = '0;
	wire         busy;
	wire         done;
	wire  [2:0]  status;
	wire  [9:0]  file_blocks;
	wire  [21:0] file_size;
	wire  [9:0]  used_blocks;
	wire  [6:0]  usage_percent;

	int mismatches;
	int awaiting;
	int checked;
	int refusals;
	int peak_used;
	int sent = 0;
	int idle_pct = 20;
	int quiet_cycles = 0;

	block_bitmap_file_allocator_unit #(
		.TOTAL_BLOCKS(TOTAL_BLOCKS),
		.BLOCK_BYTES (BLOCK_BYTES),
		.MAX_FILES   (MAX_FILES)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.file_id      (file_id),
		.size_bytes   (size_bytes),
		.done         (done),
		.status       (status),
		.file_blocks  (file_blocks),
		.file_size    (file_size),
		.used_blocks  (used_blocks),
		.usage_percent(usage_percent)
	);

	bbfa_checker #(
		.TOTAL_BLOCKS(TOTAL_BLOCKS),
		.BLOCK_BYTES (BLOCK_BYTES),
		.MAX_FILES   (MAX_FILES)
	) result_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.file_id      (file_id),
		.size_bytes   (size_bytes),
		.done         (done),
		.status       (status),
		.file_blocks  (file_blocks),
		.file_size    (file_size),
		.used_blocks  (used_blocks),
		.usage_percent(usage_percent),
		.mismatches   (mismatches),
		.awaiting     (awaiting),
		.checked      (checked),
		.refusals     (refusals),
		.peak_used    (peak_used)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", quiet_cycles);
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// present one request word, maybe after a gap, and hold it until taken
	task automatic issue_word(input action_t act, input logic [5:0] id,
			input logic [21:0] sz);
		if ($urandom_range(1, 100) <= idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		start <= 1'b1;
		action <= act;
		file_id <= id;
		size_bytes <= sz;
		do @(posedge clk); while (busy);
		sent++;
	endtask

	// random request word, mostly well-formed traffic on a small file set
	task automatic issue_random_word();
		int          pick;
		logic [5:0]  id;
		logic [21:0] sz;
		pick = $urandom_range(0, 99);
		id = ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, 15))
			: 6'($urandom_range(0, 63));
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5:
				sz = 22'($urandom_range(1, 16 * BLOCK_BYTES));
			6, 7:
				sz = 22'($urandom_range(1, 128 * BLOCK_BYTES));
			8:
				sz = 22'($urandom_range(1, 8) * BLOCK_BYTES + $urandom_range(0, 2) - 1);
			default:
				sz = 22'(CAPACITY - $urandom_range(0, CAPACITY / 2));
		endcase
		if (pick < 45)
			issue_word(ACT_CREATE, id, sz);
		else if (pick < 65)
			issue_word(ACT_DELETE, id, 22'($urandom));
		else if (pick < 90)
			issue_word(ACT_READ, id, 22'($urandom));
		else if (pick < 93)
			issue_word(ACT_CREATE, id, '0);
		else if (pick < 97)
			issue_word(ACT_CREATE, id, 22'($urandom_range(CAPACITY + 1, 22'h3FFFFF)));
		else
			issue_word(ACT_NONE, 6'($urandom), 22'($urandom));
	endtask

	// stimulus and verdict
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// misses and rejected sizes on an empty disk
		issue_word(ACT_READ, 6'd7, 22'd0);
		issue_word(ACT_DELETE, 6'd7, 22'd0);
		issue_word(ACT_CREATE, 6'd7, 22'd0);
		issue_word(ACT_CREATE, 6'd7, 22'(CAPACITY + 1));
		issue_word(ACT_CREATE, 6'd7, 22'h3FFFFF);
		// small files, then a hole filled by a non-contiguous claim
		issue_word(ACT_CREATE, 6'd0, 22'd1);
		issue_word(ACT_CREATE, 6'd63, 22'(BLOCK_BYTES));
		issue_word(ACT_CREATE, 6'd1, 22'(BLOCK_BYTES + 1));
		issue_word(ACT_DELETE, 6'd63, 22'd0);
		issue_word(ACT_CREATE, 6'd2, 22'(3 * BLOCK_BYTES));
		issue_word(ACT_READ, 6'd2, 22'd0);
		// replace an existing file
		issue_word(ACT_CREATE, 6'd0, 22'(2 * BLOCK_BYTES));
		issue_word(ACT_READ, 6'd0, 22'd0);
		// no space, and a failed replace leaves the old file deleted
		issue_word(ACT_CREATE, 6'd3, 22'(CAPACITY));
		issue_word(ACT_CREATE, 6'd1, 22'(CAPACITY));
		issue_word(ACT_READ, 6'd1, 22'd0);
		issue_word(ACT_NONE, 6'd63, 22'h3FFFFF);
		// whole disk in one file
		issue_word(ACT_DELETE, 6'd0, 22'd0);
		issue_word(ACT_DELETE, 6'd2, 22'd0);
		issue_word(ACT_CREATE, 6'd4, 22'(CAPACITY));
		issue_word(ACT_CREATE, 6'd5, 22'd1);
		issue_word(ACT_READ, 6'd4, 22'd0);
		issue_word(ACT_DELETE, 6'd4, 22'd0);
		issue_word(ACT_CREATE, 6'd9, 22'(CAPACITY - 1));
		issue_word(ACT_DELETE, 6'd9, 22'd0);

		// random traffic, gap rate changing by phase, none at the tail
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 100 == 0) begin
				case ($urandom_range(0, 2))
					0: idle_pct = 0;
					1: idle_pct = 15;
					default: idle_pct = 50;
				endcase
			end
			if (n >= RANDOM_WORDS - QUIET_TAIL)
				idle_pct = 0;
			issue_random_word();
		end
		start <= 1'b0;

		// drain
		do @(posedge clk); while (awaiting != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run: %0d request words sent, %0d result words checked", sent, checked);
		$display("disk: %0d no-space refusals, peak use %0d of %0d blocks",
			refusals, peak_used, TOTAL_BLOCKS);
		if (mismatches == 0 && awaiting == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

@@ block_bitmap_file_allocator_unit.f @@
rtl/core/bbfa_pkg.sv
rtl/core/block_bitmap_file_allocator_unit.sv
tb/bbfa_checker.sv
tb/tb.sv
